[hdl/sv39_page_table_manager_core_assert.svh]
// Assertion macros for the Sv39 page table manager.
// Clocked on clk_i, disabled while rst_ni is low; no other dependencies.
`ifndef SV39_PAGE_TABLE_MANAGER_CORE_ASSERT_SVH
`define SV39_PAGE_TABLE_MANAGER_CORE_ASSERT_SVH

// Hold cond at every clock edge.
`define SV39PTM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sv39ptm: invariant violated");

// Hold cons in the cycle where ante is seen.
`define SV39PTM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sv39ptm: implication violated");

// Hold cons in the cycle after ante.
`define SV39PTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sv39ptm: next-cycle check violated");

`endif

[hdl/sv39ptm_pkg.sv]
// Shared types and constants for the Sv39 page table manager.
// Used by the walk step unit and the top level; no dependencies.
package sv39ptm_pkg;

  localparam int unsigned TABLE_PAGES       = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 512;

  localparam int unsigned VPN_W       = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned TBL_W       = $clog2(TABLE_PAGES);
  localparam int unsigned NFT_W       = $clog2(TABLE_PAGES + 1);
  localparam int unsigned STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int unsigned ADDR_W      = TBL_W + VPN_W;

  localparam int unsigned PTE_W  = 64;
  localparam int unsigned VA_W   = 39;
  localparam int unsigned PA_W   = 56;
  localparam int unsigned OFFS_W = 12;
  localparam int unsigned PPN_W  = 44;
  localparam int unsigned FLAG_W = 8;
  localparam int unsigned LVL_W  = 2;

  typedef enum logic [1:0] {
    FN_MAP,
    FN_UNMAP,
    FN_XLATE,
    FN_NONE
  } func_e;

  typedef enum logic [2:0] {
    STS_OK,
    STS_MISALIGNED,
    STS_NO_SPACE,
    STS_MAPPED,
    STS_NOT_MAPPED,
    STS_UPPER_LEAF
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic             finish;
    logic             descend;
    logic             alloc;
    status_e          status;
    logic [TBL_W-1:0] tbl_nx;
    logic             we;
    logic [PTE_W-1:0] wdata;
    logic             flush;
    logic [PA_W-1:0]  pa_out;
  } step_t;

endpackage

[hdl/sv39ptm_ram.sv]
// Generic single-port RAM with registered read data.
// Width and depth set by parameters; no dependencies.
module sv39ptm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sv39ptm_step.sv]
// Walk step unit: judges one PTE read from the store at the current level.
// Depends on sv39ptm_pkg for widths, codes and the step_t decision bundle.
module sv39ptm_step import sv39ptm_pkg::*; (
  input  logic [PTE_W-1:0]  pte_i,
  input  logic [LVL_W-1:0]  level_i,
  input  func_e             func_i,
  input  logic [NFT_W-1:0]  nft_i,
  input  logic [PPN_W-1:0]  pa_ppn_i,
  input  logic [FLAG_W-1:0] flags_i,
  input  logic [OFFS_W-1:0] offs_i,
  output step_t             step_o
);

  logic             pte_v;
  logic             pte_rwx;
  logic [PPN_W-1:0] pte_ppn;

  assign pte_v   = pte_i[0];
  assign pte_rwx = |pte_i[3:1];
  assign pte_ppn = pte_i[PPN_W+9:10];

  always_comb begin
    step_o        = '0;
    step_o.status = STS_OK;
    if (level_i != '0) begin
      if (pte_v) begin
        if (pte_rwx || (pte_ppn >= PPN_W'(TABLE_PAGES))) begin
          step_o.finish = 1'b1;
          step_o.status = STS_UPPER_LEAF;
        end else begin
          step_o.descend = 1'b1;
          step_o.tbl_nx  = pte_ppn[TBL_W-1:0];
        end
      end else if (func_i != FN_MAP) begin
        step_o.finish = 1'b1;
        step_o.status = STS_NOT_MAPPED;
      end else if (nft_i >= NFT_W'(TABLE_PAGES)) begin
        step_o.finish = 1'b1;
        step_o.status = STS_NO_SPACE;
      end else begin
        step_o.descend = 1'b1;
        step_o.alloc   = 1'b1;
        step_o.tbl_nx  = nft_i[TBL_W-1:0];
        step_o.we      = 1'b1;
        step_o.wdata   = PTE_W'({nft_i[TBL_W-1:0], 9'd0, 1'b1});
      end
    end else begin
      step_o.finish = 1'b1;
      case (func_i)
        FN_MAP: begin
          if (pte_v) begin
            step_o.status = STS_MAPPED;
          end else begin
            step_o.we    = 1'b1;
            step_o.wdata = PTE_W'({pa_ppn_i, 2'b00, flags_i[FLAG_W-1:1], 1'b1});
          end
        end
        FN_UNMAP: begin
          if (!pte_v) begin
            step_o.status = STS_NOT_MAPPED;
          end else begin
            step_o.we    = 1'b1;
            step_o.wdata = '0;
            step_o.flush = 1'b1;
          end
        end
        FN_XLATE: begin
          if (!pte_v) begin
            step_o.status = STS_NOT_MAPPED;
          end else begin
            step_o.pa_out = {pte_ppn, offs_i};
          end
        end
        default: begin
          step_o.status = STS_OK;
        end
      endcase
    end
  end

endmodule

[hdl/sv39_page_table_manager_core.sv]
// Sv39 page table manager: map, unmap and translate over a three-level table
// held in an internal store of TABLE_PAGES pages of 512 PTEs (page 0 is the
// root, new pages come from a bump counter and are never freed). After reset
// the block sweeps the store to zero, one entry per cycle, with in_ready_o
// low. For each table level walked, an item then presents the address and
// judges the registered read data through the shared step unit; the result
// is then handed to the output register once that is free. A misaligned or
// unused-code item skips the walk. The single-port store is read once and
// written at most once per level. No new item is taken before the last has
// reached the output register, where it waits while the next item is taken.
// Depends on sv39ptm_pkg, sv39ptm_ram, sv39ptm_step and the assert header.
`include "sv39_page_table_manager_core_assert.svh"

module sv39_page_table_manager_core import sv39ptm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [VA_W-1:0]   virt_addr_i,
  input  logic [PA_W-1:0]   phys_addr_in_i,
  input  logic [FLAG_W-1:0] pte_flags_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [PA_W-1:0]   phys_addr_out_o,
  output logic              flush_valid_o,
  output logic [VA_W-1:0]   flush_vaddr_o
);

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_q;
  logic [NFT_W-1:0]   nft_q;
  logic               out_valid_q;

  func_e              func_q;
  logic [VA_W-1:0]    va_q;
  logic [PA_W-1:0]    pa_q;
  logic [FLAG_W-1:0]  flags_q;
  logic [LVL_W-1:0]   level_q;
  logic [TBL_W-1:0]   tbl_q;
  status_e            res_status_q;
  logic [PA_W-1:0]    res_pa_q;
  logic               res_flush_q;

  status_e            out_status_q;
  logic [PA_W-1:0]    out_pa_q;
  logic               out_flush_q;
  logic [VA_W-1:0]    out_vaddr_q;

  logic               in_beat;
  logic               out_free;
  logic               early;
  status_e            early_status;
  logic [VPN_W-1:0]   vpn;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [PTE_W-1:0]   ram_wdata;
  logic [PTE_W-1:0]   ram_rdata;
  step_t              step;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    early        = 1'b0;
    early_status = STS_OK;
    case (func_i)
      FN_MAP: begin
        if ((virt_addr_i[OFFS_W-1:0] != '0) || (phys_addr_in_i[OFFS_W-1:0] != '0)) begin
          early        = 1'b1;
          early_status = STS_MISALIGNED;
        end
      end
      FN_UNMAP: begin
        if (virt_addr_i[OFFS_W-1:0] != '0) begin
          early        = 1'b1;
          early_status = STS_MISALIGNED;
        end
      end
      FN_XLATE: begin
        early = 1'b0;
      end
      default: begin
        early = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (level_q)
      2'd2:    vpn = va_q[OFFS_W+3*VPN_W-1:OFFS_W+2*VPN_W];
      2'd1:    vpn = va_q[OFFS_W+2*VPN_W-1:OFFS_W+VPN_W];
      default: vpn = va_q[OFFS_W+VPN_W-1:OFFS_W];
    endcase
  end

  sv39ptm_ram #(
    .WIDTH (PTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sv39ptm_step u_step (
    .pte_i    (ram_rdata),
    .level_i  (level_q),
    .func_i   (func_q),
    .nft_i    (nft_q),
    .pa_ppn_i (pa_q[PA_W-1:OFFS_W]),
    .flags_i  (flags_q),
    .offs_i   (va_q[OFFS_W-1:0]),
    .step_o   (step)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = early ? S_RESP : S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = step.finish ? S_RESP : S_READ;
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = {tbl_q, vpn};
    ram_wdata  = step.wdata;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_CHECK: begin
        ram_we = step.we;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      nft_q       <= NFT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if ((state_q == S_CHECK) && step.alloc) begin
        nft_q <= nft_q + 1'b1;
      end
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      func_q       <= func_e'(func_i);
      va_q         <= virt_addr_i;
      pa_q         <= phys_addr_in_i;
      flags_q      <= pte_flags_i;
      level_q      <= 2'd2;
      tbl_q        <= '0;
      res_status_q <= early_status;
      res_pa_q     <= '0;
      res_flush_q  <= 1'b0;
    end
    if (state_q == S_CHECK) begin
      res_status_q <= step.status;
      res_pa_q     <= step.pa_out;
      res_flush_q  <= step.flush;
      if (step.descend) begin
        tbl_q   <= step.tbl_nx;
        level_q <= level_q - 1'b1;
      end
    end
    if ((state_q == S_RESP) && out_free) begin
      out_status_q <= res_status_q;
      out_pa_q     <= res_pa_q;
      out_flush_q  <= res_flush_q;
      out_vaddr_q  <= res_flush_q ? va_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign phys_addr_out_o = out_pa_q;
  assign flush_valid_o   = out_flush_q;
  assign flush_vaddr_o   = out_vaddr_q;

  `SV39PTM_ASSERT_ALWAYS(a_nft_range, (nft_q != '0) && (nft_q <= NFT_W'(TABLE_PAGES)))
  `SV39PTM_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready_o)
  `SV39PTM_ASSERT_IMPLIES(a_flush_ok, out_valid_q && out_flush_q, (out_status_q == STS_OK) && (out_pa_q == '0))
  `SV39PTM_ASSERT_IMPLIES(a_clear_quiet, state_q == S_CLEAR, !out_valid_q && !in_ready_o)

endmodule
